FILE: rtl/core/cstep_pkg.sv
package cstep_pkg;

   // Map geometry.
   localparam int MAP_LOG2_MAX = 9;
   localparam int MAP_ADDR_W   = 2 * MAP_LOG2_MAX;
   localparam int MAP_DEPTH    = 1 << MAP_ADDR_W;
   localparam int LOG2_W       = 4;
   localparam logic [LOG2_W-1:0] LOG2_RESET = LOG2_W'(9);

   // Marching constants in Q16.16 LSBs.
   localparam int STEP_THRESH = 6554;
   localparam int EPS_LSB     = 1;
   localparam int VERT_LIMIT  = 65536;

   // Divider geometry.
   localparam int DIV_W     = 64;
   localparam int DSR_W     = 33;
   localparam int DIV_CNT_W = 6;

   // Command codes.
   localparam logic [1:0] CMD_CAST      = 2'd0;
   localparam logic [1:0] CMD_WR_HEIGHT = 2'd1;
   localparam logic [1:0] CMD_WR_SLOPE  = 2'd2;

   // Register indexes.
   localparam logic CSR_WIDTH_LOG2  = 1'b0;
   localparam logic CSR_HEIGHT_LOG2 = 1'b1;

   // Request to the shared divider.
   typedef struct packed {
      logic                   start;
      logic [DIV_W-1:0]       dividend;
      logic [DSR_W-1:0]       divisor;
   } div_req_type;

   // Divider status.
   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   // Saturate a wide signed value to 32 bits.
   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) begin
         return 32'sh7fffffff;
      end else if (v < -64'sd2147483648) begin
         return 32'sh80000000;
      end else begin
         return $signed(v[31:0]);
      end
   endfunction

endpackage

FILE: rtl/core/cone_step_heightmap_raycast.sv
// Cone-step height-map ray caster, Q16.16. Write beats (cmd 1 and 2) store one height or slope
// entry; they give no result. A cast beat (cmd 0) gives one result beat.
// Nothing is accepted while a cast runs. A cast first finds the direction length in the
// bit-serial square root, then the ray slope with a division, and then marches: each iteration
// reads the four corner entries of both maps, does six interpolations on the one shared
// multiplier, two divisions and the position update. The 64-step serial divider sets the
// pace; at most 255 iterations run. A vertical ray stops once the height is interpolated.
// Map entries never written read as unknown values.
module cone_step_heightmap_raycast
   import cstep_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_cmd,
   input  logic [17:0]        req_map_addr,
   input  logic signed [31:0] req_map_value,
   input  logic signed [31:0] req_orig_x,
   input  logic signed [31:0] req_orig_y,
   input  logic signed [31:0] req_orig_z,
   input  logic signed [31:0] req_dir_x,
   input  logic signed [31:0] req_dir_y,
   input  logic signed [31:0] req_dir_z,
   input  logic [7:0]         req_iter_limit,
   input  logic [30:0]        req_dist_limit,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_hit,
   output logic signed [31:0] rsp_point_x,
   output logic signed [31:0] rsp_point_y,
   output logic signed [31:0] rsp_point_z,
   output logic signed [31:0] rsp_travelled,
   input  logic               csr_we,
   input  logic               csr_index,
   input  logic [3:0]         csr_wdata
);

   typedef enum logic [12:0] {
      ST_IDLE   = 13'b0000000000001,
      ST_HSQ    = 13'b0000000000010,
      ST_SQRT   = 13'b0000000000100,
      ST_RK     = 13'b0000000001000,
      ST_LOOP   = 13'b0000000010000,
      ST_READ   = 13'b0000000100000,
      ST_LERP   = 13'b0000001000000,
      ST_CHECK  = 13'b0000010000000,
      ST_DIV1   = 13'b0000100000000,
      ST_DIV2   = 13'b0001000000000,
      ST_MOVE   = 13'b0010000000000,
      ST_UPDATE = 13'b0100000000000,
      ST_DONE   = 13'b1000000000000
   } state_type;

   typedef enum logic [1:0] {
      FIN_MISS = 2'd0,
      FIN_RAY  = 2'd1,
      FIN_VERT = 2'd2
   } fin_type;

   // Control state.
   state_type           state_ff, state_in;
   logic [3:0]          sub_ff, sub_in;
   logic [5:0]          cnt_ff, cnt_in;
   logic                vert_ff, vert_in;
   fin_type             fin_ff, fin_in;
   logic [7:0]          it_ff, it_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [LOG2_W-1:0]   wl_ff, wl_in;
   logic [LOG2_W-1:0]   hl_ff, hl_in;

   // Datapath registers.
   logic signed [31:0]  px_ff, px_in, py_ff, py_in, pz_ff, pz_in;
   logic signed [31:0]  dx_ff, dx_in, dy_ff, dy_in, dz_ff, dz_in;
   logic [7:0]          n_ff, n_in;
   logic [30:0]         dlim_ff, dlim_in;
   logic [63:0]         h2_ff, h2_in;
   logic [35:0]         sq_rem_ff, sq_rem_in;
   logic [31:0]         root_ff, root_in;
   logic [31:0]         len_ff, len_in;
   logic signed [31:0]  rk_ff, rk_in;
   logic signed [31:0]  trav_ff, trav_in;
   logic signed [31:0]  hv_ff [4];
   logic signed [31:0]  hv_in [4];
   logic signed [31:0]  sv_ff [4];
   logic signed [31:0]  sv_in [4];
   logic signed [31:0]  hl1_ff, hl1_in, hl2_ff, hl2_in, alt_ff, alt_in;
   logic signed [31:0]  sl1_ff, sl1_in, sl2_ff, sl2_in, ck_ff, ck_in;
   logic signed [63:0]  q1_ff, q1_in;
   logic signed [31:0]  adv_ff, adv_in;
   logic signed [63:0]  prod_ff, prod_in;
   logic                rsp_hit_ff, rsp_hit_in;
   logic signed [31:0]  rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic signed [31:0]  rsp_z_ff, rsp_z_in, rsp_t_ff, rsp_t_in;

   // Map stores.
   logic [31:0]           height_mem [MAP_DEPTH];
   logic [31:0]           slope_mem  [MAP_DEPTH];
   logic [31:0]           hrd_ff, srd_ff;
   logic [MAP_ADDR_W-1:0] rd_addr;
   logic                  h_we, s_we;

   // Combinational helpers.
   logic                     req_fire;
   logic [LOG2_W-1:0]        wl_eff, hl_eff;
   logic [MAP_LOG2_MAX-1:0]  wmask, hmask, col1, col2, row1, row2, rd_col, rd_row;
   logic signed [33:0]       mul_a, mul_b;
   logic signed [67:0]       prod_full;
   logic signed [33:0]       ax, az;
   logic [2:0]               lj;
   logic signed [31:0]       lerp_a, lerp_b, lerp_res;
   logic signed [33:0]       lerp_t;
   logic [35:0]              sq_sh, sq_trial;
   logic [31:0]              root_next;
   logic [35:0]              sq_rem_next;
   logic signed [32:0]       k_sum;
   logic signed [63:0]       mv_sum;
   logic signed [31:0]       mv_p;
   logic                     brk;
   div_req_type              div_req;
   div_stat_type             div_stat;
   logic signed [DIV_W-1:0]  div_q;

   assign req_fire  = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign h_we      = req_fire && (req_cmd == CMD_WR_HEIGHT);
   assign s_we      = req_fire && (req_cmd == CMD_WR_SLOPE);

   // Effective map size and wrapped cell indexes.
   always_comb begin
      wl_eff = (wl_ff < LOG2_W'(1)) ? LOG2_W'(1)
             : (wl_ff > LOG2_W'(MAP_LOG2_MAX)) ? LOG2_W'(MAP_LOG2_MAX) : wl_ff;
      hl_eff = (hl_ff < LOG2_W'(1)) ? LOG2_W'(1)
             : (hl_ff > LOG2_W'(MAP_LOG2_MAX)) ? LOG2_W'(MAP_LOG2_MAX) : hl_ff;
      wmask  = MAP_LOG2_MAX'((1 << wl_eff) - 1);
      hmask  = MAP_LOG2_MAX'((1 << hl_eff) - 1);
      col1   = px_ff[16 +: MAP_LOG2_MAX] & wmask;
      col2   = (col1 + 1'b1) & wmask;
      row1   = pz_ff[16 +: MAP_LOG2_MAX] & hmask;
      row2   = (row1 + 1'b1) & hmask;
      rd_col = sub_ff[0] ? col2 : col1;
      rd_row = sub_ff[1] ? row2 : row1;
      rd_addr = (MAP_ADDR_W'(rd_row) << wl_eff) | MAP_ADDR_W'(rd_col);
   end

   // Height store.
   always_ff @(posedge clock) begin
      if (h_we) begin
         height_mem[req_map_addr] <= req_map_value;
      end
      hrd_ff <= height_mem[rd_addr];
   end

   // Slope store.
   always_ff @(posedge clock) begin
      if (s_we) begin
         slope_mem[req_map_addr] <= req_map_value;
      end
      srd_ff <= slope_mem[rd_addr];
   end

   // Interpolation operands for the lerp in progress.
   always_comb begin
      lj = sub_ff[3:1];
      case (lj)
         3'd0: begin lerp_a = hv_ff[0]; lerp_b = hv_ff[1]; end
         3'd1: begin lerp_a = hv_ff[2]; lerp_b = hv_ff[3]; end
         3'd2: begin lerp_a = hl1_ff;   lerp_b = hl2_ff;   end
         3'd3: begin lerp_a = sv_ff[0]; lerp_b = sv_ff[1]; end
         3'd4: begin lerp_a = sv_ff[2]; lerp_b = sv_ff[3]; end
         default: begin lerp_a = sl1_ff; lerp_b = sl2_ff; end
      endcase
      lerp_t = ((lj == 3'd2) || (lj == 3'd5)) ? $signed({18'b0, pz_ff[15:0]})
                                               : $signed({18'b0, px_ff[15:0]});
      lerp_res = 32'(34'(lerp_a) + $signed(prod_ff[49:16]));
   end

   // Shared multiplier operand selection.
   always_comb begin
      ax    = dx_ff[31] ? -34'(dx_ff) : 34'(dx_ff);
      az    = dz_ff[31] ? -34'(dz_ff) : 34'(dz_ff);
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_HSQ: begin
            mul_a = (sub_ff == 4'd0) ? ax : az;
            mul_b = (sub_ff == 4'd0) ? ax : az;
         end
         ST_LERP: begin
            mul_a = 34'(lerp_b) - 34'(lerp_a);
            mul_b = lerp_t;
         end
         ST_MOVE: begin
            mul_a = (sub_ff == 4'd0) ? 34'(dx_ff) : (sub_ff == 4'd1) ? 34'(dy_ff) : 34'(dz_ff);
            mul_b = 34'(adv_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      prod_full = mul_a * mul_b;
   end

   // One digit of the integer square root.
   always_comb begin
      sq_sh    = {sq_rem_ff[33:0], h2_ff[63:62]};
      sq_trial = {2'b00, root_ff, 2'b01};
      if (sq_sh >= sq_trial) begin
         sq_rem_next = sq_sh - sq_trial;
         root_next   = {root_ff[30:0], 1'b1};
      end else begin
         sq_rem_next = sq_sh;
         root_next   = {root_ff[30:0], 1'b0};
      end
   end

   // Divider operands per phase.
   always_comb begin
      k_sum = 33'(ck_ff) + 33'(rk_ff);
      div_req.start    = ((state_ff == ST_RK) || (state_ff == ST_DIV1) || (state_ff == ST_DIV2))
                         && (sub_ff == 4'd0);
      div_req.dividend = '0;
      div_req.divisor  = 33'(len_ff);
      case (state_ff)
         ST_RK:   div_req.dividend = (-64'(dy_ff)) <<< 16;
         ST_DIV1: div_req.dividend = (64'(py_ff) - 64'(alt_ff)) <<< 16;
         ST_DIV2: begin
            div_req.dividend = q1_ff <<< 16;
            div_req.divisor  = k_sum;
         end
         default: div_req.dividend = '0;
      endcase
   end

   cstep_div u_div (
      .clock    (clock),
      .reset    (reset),
      .req      (div_req),
      .stat     (div_stat),
      .quotient (div_q)
   );

   // Position update of one coordinate and the stop test.
   always_comb begin
      mv_p = (sub_ff == 4'd1) ? px_ff : (sub_ff == 4'd2) ? py_ff : pz_ff;
      mv_sum = 64'(mv_p) + (prod_ff >>> 16);
      brk = (adv_ff <= 32'(STEP_THRESH)) && (34'(py_ff) <= (34'(alt_ff) + 34'(STEP_THRESH)));
   end

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      sub_in = sub_ff;
      cnt_in = cnt_ff;
      vert_in = vert_ff;
      fin_in = fin_ff;
      it_in = it_ff;
      rsp_valid_in = rsp_valid_ff;
      wl_in = wl_ff;
      hl_in = hl_ff;
      px_in = px_ff; py_in = py_ff; pz_in = pz_ff;
      dx_in = dx_ff; dy_in = dy_ff; dz_in = dz_ff;
      n_in = n_ff;
      dlim_in = dlim_ff;
      h2_in = h2_ff;
      sq_rem_in = sq_rem_ff;
      root_in = root_ff;
      len_in = len_ff;
      rk_in = rk_ff;
      trav_in = trav_ff;
      hv_in = hv_ff;
      sv_in = sv_ff;
      hl1_in = hl1_ff; hl2_in = hl2_ff; alt_in = alt_ff;
      sl1_in = sl1_ff; sl2_in = sl2_ff; ck_in = ck_ff;
      q1_in = q1_ff;
      adv_in = adv_ff;
      prod_in = prod_full[63:0];
      rsp_hit_in = rsp_hit_ff;
      rsp_x_in = rsp_x_ff; rsp_y_in = rsp_y_ff; rsp_z_in = rsp_z_ff; rsp_t_in = rsp_t_ff;

      // Configuration writes.
      if (csr_we) begin
         if (csr_index == CSR_WIDTH_LOG2) begin
            wl_in = csr_wdata;
         end else begin
            hl_in = csr_wdata;
         end
      end

      // Result beat leaves.
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_cmd == CMD_CAST)) begin
               px_in = req_orig_x; py_in = req_orig_y; pz_in = req_orig_z;
               dx_in = req_dir_x; dy_in = req_dir_y; dz_in = req_dir_z;
               n_in = req_iter_limit;
               dlim_in = req_dist_limit;
               sub_in = '0;
               state_in = ST_HSQ;
            end
         end
         ST_HSQ: begin
            sub_in = sub_ff + 1'b1;
            if (sub_ff == 4'd1) begin
               h2_in = prod_ff;
            end else if (sub_ff == 4'd2) begin
               h2_in = h2_ff + prod_ff;
            end else if (sub_ff == 4'd3) begin
               sub_in = '0;
               if (h2_ff <= 64'(VERT_LIMIT)) begin
                  vert_in = 1'b1;
                  state_in = ST_READ;
               end else begin
                  vert_in = 1'b0;
                  sq_rem_in = '0;
                  root_in = '0;
                  cnt_in = '0;
                  state_in = ST_SQRT;
               end
            end
         end
         ST_SQRT: begin
            sq_rem_in = sq_rem_next;
            root_in = root_next;
            h2_in = {h2_ff[61:0], 2'b00};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 6'd31) begin
               len_in = root_next;
               sub_in = '0;
               state_in = ST_RK;
            end
         end
         ST_RK: begin
            if (sub_ff == 4'd0) begin
               sub_in = 4'd1;
            end else if (div_stat.done) begin
               rk_in = sat32(div_q);
               it_in = '0;
               trav_in = '0;
               state_in = ST_LOOP;
            end
         end
         ST_LOOP: begin
            if (it_ff == n_ff) begin
               fin_in = FIN_RAY;
               state_in = ST_DONE;
            end else begin
               sub_in = '0;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            sub_in = sub_ff + 1'b1;
            if (sub_ff != 4'd0) begin
               hv_in[sub_ff[1:0] - 2'd1] = $signed(hrd_ff);
               sv_in[sub_ff[1:0] - 2'd1] = $signed(srd_ff);
            end
            if (sub_ff == 4'd4) begin
               sub_in = '0;
               state_in = ST_LERP;
            end
         end
         ST_LERP: begin
            sub_in = sub_ff + 1'b1;
            if (sub_ff[0]) begin
               case (lj)
                  3'd0: hl1_in = lerp_res;
                  3'd1: hl2_in = lerp_res;
                  3'd2: alt_in = lerp_res;
                  3'd3: sl1_in = lerp_res;
                  3'd4: sl2_in = lerp_res;
                  default: ck_in = lerp_res;
               endcase
               if (vert_ff && (lj == 3'd2)) begin
                  fin_in = FIN_VERT;
                  state_in = ST_DONE;
               end else if (lj == 3'd5) begin
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            sub_in = '0;
            if ((rk_ff[31] && (-34'(rk_ff) > 34'(ck_ff))) || (k_sum <= 33'(EPS_LSB))) begin
               fin_in = FIN_MISS;
               state_in = ST_DONE;
            end else begin
               state_in = ST_DIV1;
            end
         end
         ST_DIV1: begin
            if (sub_ff == 4'd0) begin
               sub_in = 4'd1;
            end else if (div_stat.done) begin
               q1_in = div_q;
               sub_in = '0;
               state_in = ST_DIV2;
            end
         end
         ST_DIV2: begin
            if (sub_ff == 4'd0) begin
               sub_in = 4'd1;
            end else if (div_stat.done) begin
               adv_in = sat32(div_q >>> 1);
               sub_in = '0;
               state_in = ST_MOVE;
            end
         end
         ST_MOVE: begin
            sub_in = sub_ff + 1'b1;
            case (sub_ff)
               4'd1: px_in = sat32(mv_sum);
               4'd2: py_in = sat32(mv_sum);
               4'd3: begin
                  pz_in = sat32(mv_sum);
                  trav_in = sat32(64'(trav_ff) + 64'(adv_ff));
                  state_in = ST_UPDATE;
               end
               default: ;
            endcase
         end
         ST_UPDATE: begin
            if (brk) begin
               fin_in = FIN_RAY;
               state_in = ST_DONE;
            end else if (trav_ff > $signed({1'b0, dlim_ff})) begin
               fin_in = FIN_MISS;
               state_in = ST_DONE;
            end else begin
               it_in = it_ff + 1'b1;
               state_in = ST_LOOP;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
               case (fin_ff)
                  FIN_RAY: begin
                     rsp_hit_in = 1'b1;
                     rsp_x_in = px_ff; rsp_y_in = py_ff; rsp_z_in = pz_ff;
                     rsp_t_in = trav_ff;
                  end
                  FIN_VERT: begin
                     rsp_hit_in = 1'b1;
                     rsp_x_in = px_ff; rsp_y_in = alt_ff; rsp_z_in = pz_ff;
                     rsp_t_in = sat32(64'(py_ff) - 64'(alt_ff));
                  end
                  default: begin
                     rsp_hit_in = 1'b0;
                     rsp_x_in = '0; rsp_y_in = '0; rsp_z_in = '0; rsp_t_in = '0;
                  end
               endcase
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         wl_ff <= LOG2_RESET;
         hl_ff <= LOG2_RESET;
         sub_ff <= '0;
         cnt_ff <= '0;
         vert_ff <= 1'b0;
         fin_ff <= FIN_MISS;
         it_ff <= '0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         wl_ff <= wl_in;
         hl_ff <= hl_in;
         sub_ff <= sub_in;
         cnt_ff <= cnt_in;
         vert_ff <= vert_in;
         fin_ff <= fin_in;
         it_ff <= it_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      px_ff <= px_in; py_ff <= py_in; pz_ff <= pz_in;
      dx_ff <= dx_in; dy_ff <= dy_in; dz_ff <= dz_in;
      n_ff <= n_in;
      dlim_ff <= dlim_in;
      h2_ff <= h2_in;
      sq_rem_ff <= sq_rem_in;
      root_ff <= root_in;
      len_ff <= len_in;
      rk_ff <= rk_in;
      trav_ff <= trav_in;
      hv_ff <= hv_in;
      sv_ff <= sv_in;
      hl1_ff <= hl1_in; hl2_ff <= hl2_in; alt_ff <= alt_in;
      sl1_ff <= sl1_in; sl2_ff <= sl2_in; ck_ff <= ck_in;
      q1_ff <= q1_in;
      adv_ff <= adv_in;
      prod_ff <= prod_in;
      rsp_hit_ff <= rsp_hit_in;
      rsp_x_ff <= rsp_x_in; rsp_y_ff <= rsp_y_in; rsp_z_ff <= rsp_z_in; rsp_t_ff <= rsp_t_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_hit       = rsp_hit_ff;
   assign rsp_point_x   = rsp_x_ff;
   assign rsp_point_y   = rsp_y_ff;
   assign rsp_point_z   = rsp_z_ff;
   assign rsp_travelled = rsp_t_ff;

`ifndef ASSERT_OFF
   a_cast_starts: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_cmd == CMD_CAST)) |=> (state_ff == ST_HSQ))
      else $error("cast beat did not start the sequencer");
   a_iter_bound: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_READ) && !vert_ff) |-> (it_ff < n_ff))
      else $error("map read past the iteration limit");
   a_div_owner: assert property (@(posedge clock) disable iff (reset)
      div_stat.busy |-> ((state_ff == ST_RK) || (state_ff == ST_DIV1) || (state_ff == ST_DIV2)))
      else $error("divider busy outside a division phase");
`endif

endmodule

FILE: rtl/core/cstep_div.sv
module cstep_div
   import cstep_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  div_req_type             req,
   output div_stat_type            stat,
   output logic signed [DIV_W-1:0] quotient
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 neg_ff, neg_in;
   logic [DIV_W-1:0]     num_ff, num_in;
   logic [DSR_W:0]       rem_ff, rem_in;
   logic [DSR_W-1:0]     dsr_ff, dsr_in;
   logic [DSR_W:0]       rem_sh;
   logic                 ge;

   // One quotient bit per cycle, restoring, on magnitudes; sign fixed at the end.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      rem_sh  = {rem_ff[DSR_W-1:0], num_ff[DIV_W-1]};
      ge      = rem_sh >= {1'b0, dsr_ff};
      if (busy_ff) begin
         rem_in = ge ? (rem_sh - {1'b0, dsr_ff}) : rem_sh;
         num_in = {num_ff[DIV_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (req.start) begin
         neg_in  = req.dividend[DIV_W-1];
         num_in  = req.dividend[DIV_W-1] ? (~req.dividend + 1'b1) : req.dividend;
         rem_in  = '0;
         dsr_in  = req.divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
      num_ff <= num_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = neg_ff ? -$signed(num_ff) : $signed(num_ff);

`ifndef ASSERT_OFF
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff) else $error("divider done while busy");
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      (req.start && busy_ff) |-> 1'b0) else $error("divider started while busy");
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (rem_ff < {1'b0, dsr_ff})) else $error("divider remainder out of range");
`endif

endmodule

FILE: bench/cone_step_heightmap_raycast_test.sv
`timescale 1ns / 1ps

module cone_step_heightmap_raycast_test;
   import cstep_pkg::*;

   localparam int CLK_HI    = 6;
   localparam int CLK_LO    = 6;
   localparam int RST_LEN   = 9;
   localparam int MAX_CYC   = 3000000;
   localparam int DRAIN_CYC = 60;
   localparam int HOLD_LEN  = 400;

   // One beat on the request channel, with the ray result it should give.
   typedef struct {
      logic [1:0]         cmd;
      logic [17:0]        addr;
      logic signed [31:0] value;
      logic signed [31:0] ox, oy, oz, dx, dy, dz;
      logic [7:0]         iters;
      logic [30:0]        dlim;
      logic               want_hit;
      logic signed [31:0] want_x, want_y, want_z, want_trav;
   } beat_type;

   logic               clock, reset;
   logic               req_valid, req_stall;
   logic [1:0]         req_cmd;
   logic [17:0]        req_map_addr;
   logic signed [31:0] req_map_value;
   logic signed [31:0] req_orig_x, req_orig_y, req_orig_z;
   logic signed [31:0] req_dir_x, req_dir_y, req_dir_z;
   logic [7:0]         req_iter_limit;
   logic [30:0]        req_dist_limit;
   logic               rsp_valid, rsp_stall, rsp_hit;
   logic signed [31:0] rsp_point_x, rsp_point_y, rsp_point_z, rsp_travelled;
   logic               csr_we, csr_index;
   logic [3:0]         csr_wdata;

   // Testbench copy of the block state.
   logic signed [31:0] height_copy [int];
   logic signed [31:0] slope_copy [int];
   int                 width_reg, height_reg;

   beat_type pending_beats [$];
   beat_type ray_results [$];
   beat_type cur;
   int  n_offered, n_taken, n_checked, n_hits, n_writes, n_errors, cycles;
   int  send_gap, recv_gap, hold_cnt;
   bit  calm, pressure_done;

   cone_step_heightmap_raycast u_top (.*);

   // Clock.
   always begin
      clock = 1'b1;
      #CLK_HI;
      clock = 1'b0;
      #CLK_LO;
   end

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("mismatch %s: got %h expected %h (result %0d)", what, got, want, n_checked);
      n_errors++;
   endtask

   function automatic longint clip32(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic int eff_log2(input int v);
      if (v < 1) return 1;
      if (v > MAP_LOG2_MAX) return MAP_LOG2_MAX;
      return v;
   endfunction

   // Read one map entry; flags a read of an entry never written.
   function automatic longint map_entry(input bit slope, input int a, inout bit unwritten);
      if (slope) begin
         if (slope_copy.exists(a)) return longint'(slope_copy[a]);
      end else begin
         if (height_copy.exists(a)) return longint'(height_copy[a]);
      end
      unwritten = 1'b1;
      return 0;
   endfunction

   function automatic longint blend(input longint a, input longint b, input longint t);
      return a + (((b - a) * t) >>> 16);
   endfunction

   // Wrapped bilinear sample of one map.
   function automatic longint bilinear(input bit slope, input longint x, input longint z,
                                       inout bit unwritten);
      int          wl, hl, c1, c2, r1, r2;
      logic [31:0] ux, uz;
      longint      v11, v21, v12, v22;
      wl = eff_log2(width_reg);
      hl = eff_log2(height_reg);
      ux = x[31:0];
      uz = z[31:0];
      c1 = int'(ux[31:16]) & ((1 << wl) - 1);
      r1 = int'(uz[31:16]) & ((1 << hl) - 1);
      c2 = (c1 + 1) & ((1 << wl) - 1);
      r2 = (r1 + 1) & ((1 << hl) - 1);
      v11 = map_entry(slope, ((r1 << wl) | c1) & (MAP_DEPTH - 1), unwritten);
      v21 = map_entry(slope, ((r1 << wl) | c2) & (MAP_DEPTH - 1), unwritten);
      v12 = map_entry(slope, ((r2 << wl) | c1) & (MAP_DEPTH - 1), unwritten);
      v22 = map_entry(slope, ((r2 << wl) | c2) & (MAP_DEPTH - 1), unwritten);
      return blend(blend(v11, v21, longint'(ux[15:0])),
                   blend(v12, v22, longint'(ux[15:0])), longint'(uz[15:0]));
   endfunction

   function automatic bit [63:0] root_floor(input bit [63:0] v);
      bit [63:0] res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return res;
   endfunction

   // March one ray through the height field; returns 1 if it would read an unwritten entry.
   function automatic bit march_ray(inout beat_type b);
      longint    px, py, pz, dx, dy, dz, len, rk, trav, g, alt, ck, k, adv;
      bit [63:0] ax, az, h2;
      bit        unwritten;
      unwritten = 1'b0;
      px = b.ox; py = b.oy; pz = b.oz;
      dx = b.dx; dy = b.dy; dz = b.dz;
      trav = 0;
      ax = dx < 0 ? -dx : dx;
      az = dz < 0 ? -dz : dz;
      h2 = ax * ax + az * az;
      b.want_hit = 1'b1;
      if (h2 <= VERT_LIMIT) begin
         g = bilinear(1'b0, px, pz, unwritten);
         b.want_x = px; b.want_y = g; b.want_z = pz; b.want_trav = clip32(py - g);
         return unwritten;
      end
      len = longint'(root_floor(h2));
      rk = clip32((-dy * 65536) / len);
      for (int it = 0; it < b.iters; it++) begin
         alt = bilinear(1'b0, px, pz, unwritten);
         ck = bilinear(1'b1, px, pz, unwritten);
         k = ck + rk;
         if ((rk < 0 && -rk > ck) || k <= EPS_LSB) begin
            b.want_hit = 1'b0;
            break;
         end
         adv = ((py - alt) * 65536) / len;
         adv = (adv * 65536) / k;
         adv = clip32(adv >>> 1);
         px = clip32(px + ((dx * adv) >>> 16));
         py = clip32(py + ((dy * adv) >>> 16));
         pz = clip32(pz + ((dz * adv) >>> 16));
         trav = clip32(trav + adv);
         if (adv <= STEP_THRESH && py <= alt + STEP_THRESH) break;
         if (trav > longint'(b.dlim)) begin
            b.want_hit = 1'b0;
            break;
         end
      end
      if (b.want_hit) begin
         b.want_x = px; b.want_y = py; b.want_z = pz; b.want_trav = trav;
      end else begin
         b.want_x = 0; b.want_y = 0; b.want_z = 0; b.want_trav = 0;
      end
      return unwritten;
   endfunction

   // Queue a beat; writes update the copy, casts get a result or drop on unwritten reads.
   task automatic offer(input beat_type b);
      if (b.cmd == CMD_WR_HEIGHT) begin
         height_copy[int'(b.addr)] = b.value;
      end else if (b.cmd == CMD_WR_SLOPE) begin
         slope_copy[int'(b.addr)] = b.value;
      end else if (b.cmd == CMD_CAST) begin
         if (march_ray(b)) return;
      end
      pending_beats.push_back(b);
   endtask

   function automatic beat_type blank_beat();
      beat_type b;
      b = '{default: '0};
      return b;
   endfunction

   task automatic write_entry(input logic [1:0] cmd, input int a, input logic signed [31:0] v);
      beat_type b;
      b = blank_beat();
      b.cmd = cmd;
      b.addr = a[17:0];
      b.value = v;
      offer(b);
   endtask

   // Load every entry of the active map area with gentle terrain.
   task automatic fill_maps();
      int wl, hl;
      wl = eff_log2(width_reg);
      hl = eff_log2(height_reg);
      for (int a = 0; a < (1 << (wl + hl)); a++) begin
         write_entry(CMD_WR_HEIGHT, a, $urandom_range(0, 3 << 16));
         write_entry(CMD_WR_SLOPE, a, $urandom_range(32'h4000, 32'h30000));
      end
   endtask

   // A well-formed ray: above the terrain, heading sideways and mostly down.
   function automatic beat_type plain_ray();
      beat_type b;
      int       span;
      b = blank_beat();
      b.cmd = CMD_CAST;
      span = 3 << (eff_log2(width_reg) + 16);
      b.ox = int'($urandom_range(0, 2 * span)) - span;
      span = 3 << (eff_log2(height_reg) + 16);
      b.oz = int'($urandom_range(0, 2 * span)) - span;
      b.oy = $urandom_range(4 << 16, 10 << 16);
      b.dx = $urandom_range(32'h4000, 32'h20000);
      b.dz = $urandom_range(32'h4000, 32'h20000);
      if ($urandom_range(0, 1)) b.dx = -b.dx;
      if ($urandom_range(0, 1)) b.dz = -b.dz;
      b.dy = -int'($urandom_range(0, 32'h10000));
      if ($urandom_range(0, 9) == 0) b.dy = $urandom_range(1, 32'h8000);
      b.iters = $urandom_range(1, 12);
      if ($urandom_range(0, 60) == 0) b.iters = 8'hff;
      b.dlim = $urandom_range(32'h8000, 32'h400000);
      return b;
   endfunction

   // Anything goes: every field random, mostly few iterations to bound the run.
   function automatic beat_type wild_beat();
      beat_type b;
      b.cmd = $urandom_range(0, 3);
      b.addr = $urandom;
      b.value = $urandom;
      b.ox = $urandom; b.oy = $urandom; b.oz = $urandom;
      b.dx = $urandom; b.dy = $urandom; b.dz = $urandom;
      b.iters = $urandom_range(0, 15);
      if ($urandom_range(0, 7) == 0) b.iters = $urandom;
      b.dlim = $urandom;
      return b;
   endfunction

   // A nearly vertical ray over a cell whose four corners get written first.
   task automatic vertical_ray(input int col, input int row);
      beat_type b;
      int       wl, hl;
      wl = eff_log2(width_reg);
      hl = eff_log2(height_reg);
      for (int i = 0; i < 4; i++) begin
         write_entry(CMD_WR_HEIGHT, ((((row + i / 2) & ((1 << hl) - 1)) << wl)
                     | ((col + i % 2) & ((1 << wl) - 1))), $urandom);
      end
      b = blank_beat();
      b.cmd = CMD_CAST;
      b.ox = (col << 16) | $urandom_range(0, 16'hffff);
      b.oz = (row << 16) | $urandom_range(0, 16'hffff);
      b.oy = $urandom;
      b.dx = int'($urandom_range(0, 254)) - 127;
      b.dz = int'($urandom_range(0, 254)) - 127;
      b.dy = $urandom;
      b.iters = $urandom;
      b.dlim = $urandom;
      offer(b);
   endtask

   task automatic wait_idle();
      wait (pending_beats.size() == 0 && n_taken == n_offered && ray_results.size() == 0);
      repeat (DRAIN_CYC) @(posedge clock);
   endtask

   task automatic set_reg(input logic idx, input int v);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v[3:0];
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_WIDTH_LOG2) width_reg = v;
      else height_reg = v;
   endtask

   task automatic random_part(input int count);
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(0, 9))
            0: offer(wild_beat());
            1: write_entry($urandom_range(1, 2), $urandom & ((1 << (eff_log2(width_reg)
                           + eff_log2(height_reg))) - 1), $urandom_range(0, 4 << 16));
            default: offer(plain_ray());
         endcase
      end
   endtask

   // Driver: a new beat goes out at the falling edge once the previous one is taken.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap <= 0;
      end else if (!(req_valid && n_taken != n_offered)) begin
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_valid <= 1'b0;
         end else if (pending_beats.size() > 0 && !calm && $urandom_range(0, 7) == 0) begin
            send_gap <= $urandom_range(0, 8);
            req_valid <= 1'b0;
         end else if (pending_beats.size() > 0) begin
            cur = pending_beats.pop_front();
            req_cmd <= cur.cmd;
            req_map_addr <= cur.addr;
            req_map_value <= cur.value;
            req_orig_x <= cur.ox;
            req_orig_y <= cur.oy;
            req_orig_z <= cur.oz;
            req_dir_x <= cur.dx;
            req_dir_y <= cur.dy;
            req_dir_z <= cur.dz;
            req_iter_limit <= cur.iters;
            req_dist_limit <= cur.dlim;
            req_valid <= 1'b1;
            n_offered <= n_offered + 1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Accepted request beats: casts leave an expected result behind.
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         n_taken <= n_taken + 1;
         if (cur.cmd == CMD_CAST) ray_results.push_back(cur);
         else if (cur.cmd != 2'd3) n_writes++;
      end
   end

   // Receiver stalls: short random bursts plus one long hold-off.
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         recv_gap <= 0;
         hold_cnt <= 0;
      end else if (hold_cnt > 0) begin
         hold_cnt <= hold_cnt - 1;
         rsp_stall <= 1'b1;
      end else if (!pressure_done && n_checked >= 20) begin
         pressure_done <= 1'b1;
         hold_cnt <= HOLD_LEN;
         rsp_stall <= 1'b1;
      end else if (recv_gap > 0) begin
         recv_gap <= recv_gap - 1;
         rsp_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
         recv_gap <= $urandom_range(0, 8);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Result checker.
   always @(posedge clock) begin
      beat_type w;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (ray_results.size() == 0) begin
            report("unexpected result", rsp_hit, 0);
         end else begin
            w = ray_results.pop_front();
            if (rsp_hit !== w.want_hit) report("hit", rsp_hit, w.want_hit);
            if (rsp_point_x !== w.want_x) report("point_x", rsp_point_x, w.want_x);
            if (rsp_point_y !== w.want_y) report("point_y", rsp_point_y, w.want_y);
            if (rsp_point_z !== w.want_z) report("point_z", rsp_point_z, w.want_z);
            if (rsp_travelled !== w.want_trav) report("travelled", rsp_travelled, w.want_trav);
            if (w.want_hit) n_hits++;
         end
         n_checked++;
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > MAX_CYC) begin
         $display("timeout after %0d cycles", cycles);
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      beat_type b;
      reset = 1'b1;
      req_valid = 1'b0;
      req_cmd = '0; req_map_addr = '0; req_map_value = '0;
      req_orig_x = '0; req_orig_y = '0; req_orig_z = '0;
      req_dir_x = '0; req_dir_y = '0; req_dir_z = '0;
      req_iter_limit = '0; req_dist_limit = '0;
      rsp_stall = 1'b0;
      csr_we = 1'b0; csr_index = 1'b0; csr_wdata = '0;
      n_offered = 0; n_taken = 0; n_checked = 0; n_hits = 0; n_writes = 0;
      n_errors = 0; cycles = 0; calm = 1'b0; pressure_done = 1'b0;
      width_reg = LOG2_RESET;
      height_reg = LOG2_RESET;
      repeat (RST_LEN) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Full-size map after reset: vertical rays, including wrap at the far corner.
      vertical_ray(5, 7);
      vertical_ray(511, 511);
      vertical_ray(0, 0);
      // Zero iterations return the origin; extremes of the origin and direction.
      b = blank_beat();
      b.cmd = CMD_CAST;
      b.ox = 32'sh80000000; b.oy = 32'sh7fffffff; b.oz = 32'sh7fffffff;
      b.dx = 32'sh80000000; b.dy = 32'sh80000000; b.dz = 32'sh7fffffff;
      offer(b);
      b.ox = 32'sh7fffffff; b.oz = 32'sh80000000; b.dx = 32'sh10000;
      offer(b);
      // Unknown command is dropped.
      b = wild_beat();
      b.cmd = 2'd3;
      offer(b);
      wait_idle();

      // Register values below range clamp to the smallest 2 x 2 map.
      set_reg(CSR_WIDTH_LOG2, 0);
      set_reg(CSR_HEIGHT_LOG2, 0);
      fill_maps();
      b = plain_ray();
      b.iters = 20;
      offer(b);
      b.dlim = 0;
      offer(b);
      // Flat slope with a level ray gives no cone, and a rising ray breaks the slope rule.
      for (int a = 0; a < 4; a++) write_entry(CMD_WR_SLOPE, a, 0);
      b.dlim = 31'h7fffffff;
      b.dy = 0;
      offer(b);
      b.dy = 32'h1000;
      offer(b);
      fill_maps();
      random_part(40);
      wait_idle();

      set_reg(CSR_WIDTH_LOG2, 2);
      set_reg(CSR_HEIGHT_LOG2, 3);
      fill_maps();
      random_part(50);
      wait_idle();

      // Largest map again, through the clamp from above.
      set_reg(CSR_WIDTH_LOG2, 9);
      set_reg(CSR_HEIGHT_LOG2, 15);
      for (int i = 0; i < 6; i++) vertical_ray($urandom_range(0, 511), $urandom_range(0, 511));
      b = wild_beat();
      b.cmd = CMD_CAST;
      b.iters = 0;
      offer(b);
      wait_idle();

      set_reg(CSR_WIDTH_LOG2, 3);
      set_reg(CSR_HEIGHT_LOG2, 1);
      fill_maps();
      random_part(40);
      wait (pending_beats.size() == 0);
      calm = 1'b1;
      random_part(30);
      wait_idle();

      $display("checked %0d ray results (%0d hits, %0d misses) after %0d map writes,",
               n_checked, n_hits, n_checked - n_hits, n_writes);
      $display("over map sizes from 2 x 2 to 512 x 512, with %0d mismatches", n_errors);
      if (n_errors == 0 && ray_results.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

FILE: files.f
rtl/core/cstep_pkg.sv
rtl/core/cstep_div.sv
rtl/core/cone_step_heightmap_raycast.sv
bench/cone_step_heightmap_raycast_test.sv
